/* hdl/vpfl_pkg.sv */
package vpfl_pkg;

	localparam int TRIG_FRAC_BITS = 15;
	localparam int TRIG_W = 17;
	localparam int DIST_W = 13;
	localparam int ANG_W = 8;
	localparam int NUM_W = 48;
	localparam int DEN_W = 34;
	localparam int OUT_W = 16;
	localparam int CNT_OUT_W = 11;
	localparam int TAB_N = 91;

	typedef struct packed {
		logic load;
		logic trig;
		logic mul;
		logic sub;
		logic pair_go;
		logic acc;
		logic skip;
		logic mean_go;
		logic mean_ld;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic none;
		logic pair_last;
		logic den_zero;
		logic div_done;
		logic no_pairs;
		logic out_busy;
	} stat_t;

	// shift and subtract quotient for the table build; elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Taylor series in Q30, rounded to the trig fraction width; elaboration only
	function automatic logic [15:0] trig_q(input int unsigned d, input bit want_cos);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] dv;
		longint ss;
		longint cc;
		longint r;
		x = udiv64(64'(d) * 64'd3373259426, 64'd180);
		x2 = (x * x) >> 30;
		t = x;
		ss = longint'(x);
		for (int k = 1; k <= 8; k++) begin
			dv = 64'((2 * k) * (2 * k + 1));
			t = udiv64((t * x2) >> 30, dv);
			ss = ((k & 1) == 1) ? ss - longint'(t) : ss + longint'(t);
		end
		t = 64'd1073741824;
		cc = 64'sd1073741824;
		for (int k = 1; k <= 8; k++) begin
			dv = 64'((2 * k - 1) * (2 * k));
			t = udiv64((t * x2) >> 30, dv);
			cc = ((k & 1) == 1) ? cc - longint'(t) : cc + longint'(t);
		end
		r = want_cos ? cc : ss;
		if (r <= 0) begin
			return 16'd0;
		end
		return 16'((r + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS));
	endfunction

	function automatic logic [TAB_N*16-1:0] build_tab(input bit want_cos);
		logic [TAB_N*16-1:0] tab;
		tab = '0;
		for (int d = 0; d < TAB_N; d++) begin
			tab[d*16 +: 16] = trig_q(d, want_cos);
		end
		return tab;
	endfunction

	localparam logic [TAB_N*16-1:0] SIN_TAB = build_tab(1'b0);
	localparam logic [TAB_N*16-1:0] COS_TAB = build_tab(1'b1);

	// returns {sin, cos}, each signed TRIG_W
	function automatic logic [2*TRIG_W-1:0] trig_lookup(input logic [ANG_W-1:0] ang);
		logic [ANG_W-1:0] a;
		logic [ANG_W-1:0] idx;
		logic neg;
		logic cneg;
		logic signed [TRIG_W-1:0] s;
		logic signed [TRIG_W-1:0] c;
		neg = (ang >= 8'd180);
		a = neg ? ang - 8'd180 : ang;
		cneg = (a > 8'd90);
		idx = cneg ? 8'd180 - a : a;
		s = TRIG_W'(SIN_TAB[idx*16 +: 16]);
		c = TRIG_W'(COS_TAB[idx*16 +: 16]);
		if (cneg ^ neg) begin
			c = -c;
		end
		if (neg) begin
			s = -s;
		end
		return {s, c};
	endfunction

	function automatic logic signed [OUT_W-1:0] sat16(input logic signed [NUM_W-1:0] v);
		if (v > NUM_W'(32767)) begin
			return 16'sh7fff;
		end
		if (v < -NUM_W'(32768)) begin
			return 16'sh8000;
		end
		return OUT_W'(v);
	endfunction

endpackage

/* hdl/vpfl_div.sv */
module vpfl_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [vpfl_pkg::NUM_W-1:0]      num,
	input  logic signed [vpfl_pkg::DEN_W-1:0]      den,
	output logic                                   done,
	output logic signed [vpfl_pkg::NUM_W-1:0]      quot
);
	localparam int NW = vpfl_pkg::NUM_W;
	localparam int DW = vpfl_pkg::DEN_W;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] nmag_q;
	logic [DW-1:0] dmag_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          qbit;

	assign trial = {rem_q, nmag_q[NW-1]};
	assign qbit = (trial >= {1'b0, dmag_q});

	// restoring divide on magnitudes, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nmag_q <= num[NW-1] ? NW'(-num) : NW'(num);
			dmag_q <= den[DW-1] ? DW'(-den) : DW'(den);
			rem_q <= '0;
			neg_q <= num[NW-1] ^ den[DW-1];
		end else if (busy_q) begin
			rem_q <= qbit ? DW'(trial - {1'b0, dmag_q}) : DW'(trial);
			nmag_q <= {nmag_q[NW-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed(nmag_q) : $signed(nmag_q);
endmodule

/* hdl/vpfl_ctrl.sv */
module vpfl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  last_line,
	input  vpfl_pkg::stat_t       stat,
	output logic                  in_ready,
	output vpfl_pkg::cmd_t        cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHK   = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_TRIG  = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_SUB   = 4'd5;
	localparam logic [3:0] S_DIVGO = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;
	localparam logic [3:0] S_MEAN  = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_line) state_d = S_CHK;
				end
			end
			S_CHK: state_d = stat.none ? S_FIN : S_RD;
			S_RD: state_d = S_TRIG;
			S_TRIG: begin
				cmd.trig = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SUB;
			end
			S_SUB: begin
				cmd.sub = 1'b1;
				state_d = S_DIVGO;
			end
			S_DIVGO: begin
				if (stat.den_zero) begin
					cmd.skip = 1'b1;
					state_d = stat.pair_last ? S_FIN : S_RD;
				end else begin
					cmd.pair_go = 1'b1;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.acc = 1'b1;
					state_d = stat.pair_last ? S_FIN : S_RD;
				end
			end
			S_FIN: begin
				if (stat.no_pairs) begin
					state_d = S_OUT;
				end else begin
					cmd.mean_go = 1'b1;
					state_d = S_MEAN;
				end
			end
			S_MEAN: begin
				if (stat.div_done) begin
					cmd.mean_ld = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!stat.out_busy) begin
					cmd.out_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

/* hdl/vpfl_dp.sv */
module vpfl_dp #(
	parameter int MAX_SIDE_LINES = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  vpfl_pkg::cmd_t                        cmd,
	output vpfl_pkg::stat_t                       stat,
	input  logic signed [vpfl_pkg::DIST_W-1:0]    line_distance,
	input  logic [vpfl_pkg::ANG_W-1:0]            line_angle,
	input  logic                                  cfg_we,
	input  logic [1:0]                            cfg_index,
	input  logic [7:0]                            cfg_data,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic signed [vpfl_pkg::OUT_W-1:0]     point_x,
	output logic signed [vpfl_pkg::OUT_W-1:0]     point_y,
	output logic                                  found,
	output logic [vpfl_pkg::CNT_OUT_W-1:0]        pair_count
);
	localparam int N = MAX_SIDE_LINES;
	localparam int IDX_W = (N > 1) ? $clog2(N) : 1;
	localparam int CNT_W = $clog2(N + 1);
	localparam int PAIR_W = $clog2(N * N + 1);
	localparam int SUM_W = 17 + PAIR_W;
	localparam int DW = vpfl_pkg::DIST_W;
	localparam int AW = vpfl_pkg::ANG_W;
	localparam int TW = vpfl_pkg::TRIG_W;
	localparam int NW = vpfl_pkg::NUM_W;
	localparam int EW = vpfl_pkg::DEN_W;
	localparam int OW = vpfl_pkg::OUT_W;
	localparam int PW = 2 * TW;
	localparam int QW = DW + TW;

	localparam logic [1:0] REG_LL = 2'd0;
	localparam logic [1:0] REG_LH = 2'd1;
	localparam logic [1:0] REG_RL = 2'd2;
	localparam logic [1:0] REG_RH = 2'd3;

	logic [7:0] left_lo_q, left_hi_q, right_lo_q, right_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_lo_q <= 8'd10;
			left_hi_q <= 8'd60;
			right_lo_q <= 8'd110;
			right_hi_q <= 8'd170;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LL: left_lo_q <= cfg_data;
				REG_LH: left_hi_q <= cfg_data;
				REG_RL: right_lo_q <= cfg_data;
				REG_RH: right_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// line stores
	logic [DW+AW-1:0] lmem [N];
	logic [DW+AW-1:0] rmem [N];
	logic [DW+AW-1:0] lrd_q, rrd_q;
	logic [CNT_W-1:0] lcnt_q, rcnt_q;
	logic [IDX_W-1:0] i_q, j_q;
	logic in_left, in_right, wr_left, wr_right;

	assign in_left = (left_lo_q < line_angle) && (line_angle < left_hi_q);
	assign in_right = !in_left && (right_lo_q < line_angle) && (line_angle < right_hi_q);
	assign wr_left = cmd.load && in_left && (lcnt_q < CNT_W'(N));
	assign wr_right = cmd.load && in_right && (rcnt_q < CNT_W'(N));

	always_ff @(posedge clk) begin
		if (wr_left) lmem[lcnt_q[IDX_W-1:0]] <= {line_distance, line_angle};
		if (wr_right) rmem[rcnt_q[IDX_W-1:0]] <= {line_distance, line_angle};
		lrd_q <= lmem[i_q];
		rrd_q <= rmem[j_q];
	end

	logic pair_last, next_pair;
	logic [PAIR_W-1:0] pairs_q;

	assign pair_last = ((CNT_W'(i_q) + CNT_W'(1)) == lcnt_q) &&
		((CNT_W'(j_q) + CNT_W'(1)) == rcnt_q);
	assign next_pair = cmd.acc || cmd.skip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcnt_q <= '0;
			rcnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			if (cmd.out_ld) begin
				lcnt_q <= '0;
				rcnt_q <= '0;
			end else begin
				if (wr_left) lcnt_q <= lcnt_q + CNT_W'(1);
				if (wr_right) rcnt_q <= rcnt_q + CNT_W'(1);
			end
			if (cmd.load) begin
				i_q <= '0;
				j_q <= '0;
			end else if (next_pair) begin
				if ((CNT_W'(j_q) + CNT_W'(1)) == rcnt_q) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
		end
	end

	// per-pair arithmetic
	logic signed [TW-1:0] sl_q, cl_q, sr_q, cr_q;
	logic signed [DW-1:0] dl_q, dr_q;
	logic [2*TW-1:0] ltrig, rtrig;
	logic signed [PW-1:0] p_sc_s2, p_cs_s2;
	logic signed [QW-1:0] p_xa_s2, p_xb_s2, p_ya_s2, p_yb_s2;
	logic signed [EW-1:0] den_q;
	logic signed [NW-1:0] nx_q, ny_q;

	assign ltrig = vpfl_pkg::trig_lookup(lrd_q[AW-1:0]);
	assign rtrig = vpfl_pkg::trig_lookup(rrd_q[AW-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.trig) begin
			sl_q <= ltrig[2*TW-1:TW];
			cl_q <= ltrig[TW-1:0];
			sr_q <= rtrig[2*TW-1:TW];
			cr_q <= rtrig[TW-1:0];
			dl_q <= lrd_q[DW+AW-1:AW];
			dr_q <= rrd_q[DW+AW-1:AW];
		end
		if (cmd.mul) begin
			p_sc_s2 <= sl_q * cr_q;
			p_cs_s2 <= cl_q * sr_q;
			p_xa_s2 <= QW'(dr_q) * QW'(sl_q);
			p_xb_s2 <= QW'(dl_q) * QW'(sr_q);
			p_ya_s2 <= QW'(dl_q) * QW'(cr_q);
			p_yb_s2 <= QW'(dr_q) * QW'(cl_q);
		end
		if (cmd.sub) begin
			den_q <= EW'(p_sc_s2) - EW'(p_cs_s2);
			nx_q <= (NW'(p_xa_s2) - NW'(p_xb_s2)) <<< vpfl_pkg::TRIG_FRAC_BITS;
			ny_q <= (NW'(p_ya_s2) - NW'(p_yb_s2)) <<< vpfl_pkg::TRIG_FRAC_BITS;
		end
	end

	// dividers shared by the per-pair quotients and the final mean
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
	logic div_go, dx_done, dy_done;
	logic signed [NW-1:0] num_x, num_y, qx, qy;
	logic signed [EW-1:0] dden;
	logic signed [OW-1:0] sx, sy;

	assign div_go = cmd.pair_go || cmd.mean_go;
	assign num_x = cmd.mean_go ? NW'(sum_x_q) : nx_q;
	assign num_y = cmd.mean_go ? NW'(sum_y_q) : ny_q;
	assign dden = cmd.mean_go ? EW'(pairs_q) : den_q;
	assign sx = vpfl_pkg::sat16(qx);
	assign sy = vpfl_pkg::sat16(qy);

	vpfl_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num(num_x), .den(dden),
		.done(dx_done), .quot(qx)
	);
	vpfl_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num(num_y), .den(dden),
		.done(dy_done), .quot(qy)
	);

	logic signed [OW-1:0] mx_q, my_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (cmd.load) begin
			pairs_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (cmd.acc) begin
			pairs_q <= pairs_q + PAIR_W'(1);
			sum_x_q <= sum_x_q + SUM_W'(sx);
			sum_y_q <= sum_y_q + SUM_W'(sy);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mean_ld) begin
			mx_q <= sx;
			my_q <= sy;
		end
	end

	// output word register
	logic out_valid_q;
	logic signed [OW-1:0] px_q, py_q;
	logic found_q;
	logic [vpfl_pkg::CNT_OUT_W-1:0] pc_q;
	logic no_pairs;

	assign no_pairs = (pairs_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			px_q <= no_pairs ? '0 : mx_q;
			py_q <= no_pairs ? '0 : my_q;
			found_q <= !no_pairs;
			pc_q <= (32'(pairs_q) > 32'd2047) ? 11'h7ff : 11'(pairs_q);
		end
	end

	assign out_valid = out_valid_q;
	assign point_x = px_q;
	assign point_y = py_q;
	assign found = found_q;
	assign pair_count = pc_q;

	assign stat.none = (lcnt_q == '0) || (rcnt_q == '0);
	assign stat.pair_last = pair_last;
	assign stat.den_zero = (den_q == '0);
	assign stat.div_done = dx_done && dy_done;
	assign stat.no_pairs = no_pairs;
	assign stat.out_busy = out_valid_q && !out_ready;
endmodule

/* hdl/vanishing_point_from_lines.sv */
// Lines: one word per cycle while no frame is being resolved.
// After the last line, each non-parallel left-right pair runs through the 48-bit dividers
// and each parallel pair is skipped; the mean is then divided out and the result is
// loaded to the output, waiting while the output stalls. With no pair, the mean is skipped.
// The next frame's lines are taken once the result is in the output register.
// arst_n clears control, counts, sums and the angle windows (10,60,110,170).
module vanishing_point_from_lines #(
	parameter int MAX_SIDE_LINES = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [vpfl_pkg::DIST_W-1:0]   line_distance,
	input  logic [vpfl_pkg::ANG_W-1:0]           line_angle,
	input  logic                                 last_line,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [vpfl_pkg::OUT_W-1:0]    point_x,
	output logic signed [vpfl_pkg::OUT_W-1:0]    point_y,
	output logic                                 found,
	output logic [vpfl_pkg::CNT_OUT_W-1:0]       pair_count,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [7:0]                           cfg_data
);
	vpfl_pkg::cmd_t  cmd;
	vpfl_pkg::stat_t stat;

	vpfl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .last_line(last_line),
		.stat(stat), .in_ready(in_ready), .cmd(cmd)
	);

	vpfl_dp #(.MAX_SIDE_LINES(MAX_SIDE_LINES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.line_distance(line_distance), .line_angle(line_angle),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_ready(out_ready), .out_valid(out_valid),
		.point_x(point_x), .point_y(point_y), .found(found), .pair_count(pair_count)
	);
endmodule

/* hdl/vpfl_chk.sv */
module vpfl_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 last_line,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [vpfl_pkg::OUT_W-1:0]    point_x,
	input logic signed [vpfl_pkg::OUT_W-1:0]    point_y,
	input logic                                 found,
	input logic [vpfl_pkg::CNT_OUT_W-1:0]       pair_count
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y))
		else $error("output word changed while stalled");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> point_x == 0 && point_y == 0 && pair_count == 0)
		else $error("empty result not zero");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> pair_count != 0)
		else $error("found with no pairs");

	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !last_line |=> in_ready)
		else $error("stalled within a frame");
endmodule

bind vanishing_point_from_lines vpfl_chk u_chk (.*);
